/* hw/rtl/tpm_pkg.sv */
`default_nettype none
package tpm_pkg;

  localparam int TPM_MAX_POINTS = 1024;
  localparam int TPM_COORD_BITS = 20;
  localparam int TPM_DIR_BITS   = 16;

  localparam int POS_W      = 20;
  localparam int DIR_W      = 16;
  localparam int TOL_W      = 19;
  localparam int IDX_W      = 10;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int SHIFT_W    = 5;
  localparam int TOL2_W     = 2 * TOL_W;
  localparam int TOLT_W     = TOL_W + 9;

  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_CENTROID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_CHECK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLACK_SHIFT     = 3'd5;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [TOL_W-1:0]        match_distance;
  } tpm_in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic             all_found;
    logic             overflowed;
  } tpm_out_t;

  typedef struct packed {
    logic start;
    logic valid;
    logic pass2;
    logic dir_check;
  } tpm_scan_ctrl_t;

  typedef struct packed {
    logic busy;
    logic found;
  } tpm_scan_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/tpm_channels.sv */
`default_nettype none
interface tpm_in_if import tpm_pkg::*; ();
  logic    valid;
  logic    ready;
  tpm_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tpm_out_if import tpm_pkg::*; ();
  logic     valid;
  logic     ready;
  tpm_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tpm_ram.sv */
`default_nettype none
module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tpm_divider.sv */
`default_nettype none
module tpm_divider #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 11,
  localparam int CW = $clog2(NUM_W)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tpm_scan.sv */
`default_nettype none
module tpm_scan import tpm_pkg::*; #(
  parameter int MAX_POINTS = TPM_MAX_POINTS,
  parameter int COORD_BITS = TPM_COORD_BITS,
  parameter int DIR_BITS   = TPM_DIR_BITS,
  localparam int AW   = $clog2(MAX_POINTS),
  localparam int C    = COORD_BITS,
  localparam int D    = DIR_BITS,
  localparam int RW   = 3 * C + 3 * D,
  localparam int SQ   = 2 * C + 2,
  localparam int WIN  = ((SQ > TOLT_W) ? SQ : TOLT_W) + 2,
  localparam int CMPW = (SQ > TOL2_W) ? SQ : TOL2_W,
  localparam int DOTW = 2 * D + 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tpm_scan_ctrl_t     ctrl,
  input  wire logic [AW-1:0]      idx,
  input  wire logic [RW-1:0]      rdata,
  input  wire logic [2:0][C-1:0]  q,
  input  wire logic [2:0][C-1:0]  o,
  input  wire logic [2:0][D-1:0]  qd,
  input  wire logic signed [WIN:0] lo,
  input  wire logic [WIN-1:0]     hi,
  input  wire logic [TOL2_W-1:0]  tol2,
  output tpm_scan_stat_t          stat,
  output logic [AW-1:0]           best_idx
);

  logic [2:0][SQ-1:0]   a_m;
  logic [2:0][SQ-1:0]   a_d;
  logic [2:0][2*D-1:0]  a_dot;
  logic                 a_rz;
  logic                 a_v;
  logic [AW-1:0]        a_idx;

  logic [SQ-1:0]          b_m;
  logic [SQ-1:0]          b_d;
  logic signed [DOTW-1:0] b_dot;
  logic                   b_rz;
  logic                   b_v;
  logic [AW-1:0]          b_idx;

  logic          have_low;
  logic [SQ-1:0] low_m;
  logic [AW-1:0] low_idx;
  logic          found;
  logic [SQ-1:0] best_d;
  logic [SQ-1:0] best_m;

  logic [2:0][SQ-1:0]  m_c;
  logic [2:0][SQ-1:0]  d_c;
  logic [2:0][2*D-1:0] dot_c;
  logic                rz_c;

  always_comb begin
    logic signed [C-1:0] p;
    logic signed [D-1:0] rd;
    logic signed [C:0]   dm;
    logic signed [C:0]   dq;
    rz_c = 1'b1;
    for (int k = 0; k < 3; k++) begin
      p  = $signed(rdata[k*C +: C]);
      rd = $signed(rdata[3*C + k*D +: D]);
      dm = $signed({p[C-1], p}) - $signed({o[k][C-1], o[k]});
      dq = $signed({q[k][C-1], q[k]}) - $signed({p[C-1], p});
      m_c[k]   = $unsigned(SQ'(dm) * SQ'(dm));
      d_c[k]   = $unsigned(SQ'(dq) * SQ'(dq));
      dot_c[k] = $signed(qd[k]) * rd;
      if (rd != '0) begin
        rz_c = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_m   <= m_c;
    a_d   <= d_c;
    a_dot <= dot_c;
    a_rz  <= rz_c;
    a_idx <= idx;
    b_m   <= a_m[0] + a_m[1] + a_m[2];
    b_d   <= a_d[0] + a_d[1] + a_d[2];
    b_dot <= DOTW'($signed(a_dot[0])) + DOTW'($signed(a_dot[1]))
           + DOTW'($signed(a_dot[2]));
    b_rz  <= a_rz;
    b_idx <= a_idx;
  end

  logic m_lt_lo;
  logic m_lt_hi;
  logic d_ok;
  logic dir_ok;
  logic qz;
  logic cand;
  logic better;

  assign qz      = (qd == '0);
  assign m_lt_lo = $signed({{(WIN + 1 - SQ){1'b0}}, b_m}) < lo;
  assign m_lt_hi = WIN'(b_m) < hi;
  assign d_ok    = CMPW'(b_d) <= CMPW'(tol2);
  assign dir_ok  = !ctrl.dir_check || b_dot < 0 || (qz && b_rz);
  assign cand    = m_lt_hi && (!m_lt_lo || (have_low && b_idx == low_idx)) && d_ok && dir_ok;
  assign better  = !found || b_d < best_d || (b_d == best_d && b_m < best_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v      <= 1'b0;
      b_v      <= 1'b0;
      have_low <= 1'b0;
      found    <= 1'b0;
    end else begin
      a_v <= ctrl.valid;
      b_v <= a_v;
      if (ctrl.start) begin
        have_low <= 1'b0;
        found    <= 1'b0;
      end else if (b_v && !ctrl.pass2) begin
        if (m_lt_lo && (!have_low || b_m >= low_m)) begin
          have_low <= 1'b1;
          low_m    <= b_m;
          low_idx  <= b_idx;
        end
      end else if (b_v && cand && better) begin
        found    <= 1'b1;
        best_d   <= b_d;
        best_m   <= b_m;
        best_idx <= b_idx;
      end
    end
  end

  assign stat.busy  = a_v | b_v;
  assign stat.found = found;

endmodule
`default_nettype wire

/* hw/rtl/tolerance_point_matcher.sv */
`default_nettype none
// Channel  Role    Transaction
// req      sink    clear, load or query one reference/query point
// rsp      source  one match result per query
// cfg      write   register index and data, one write per cycle
//
// Clear, load and ignored actions return no result and leave the matcher idle.
// A query on a nonempty store makes two passes over the point memory, one entry per
// cycle from its single read port, through a three-stage pipe. An empty store reads
// no entries. When the centroid must be recomputed from a nonempty store, the
// one-bit-per-cycle divider first runs once for each of the three coordinates.
// Reset is synchronous and needs no memory clearing pass.
// A waiting result holds only the final step of the next query.
module tolerance_point_matcher import tpm_pkg::*; #(
  parameter int MAX_POINTS = TPM_MAX_POINTS,
  parameter int COORD_BITS = TPM_COORD_BITS,
  parameter int DIR_BITS   = TPM_DIR_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  tpm_in_if.sink                     req,
  tpm_out_if.source                  rsp,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int C     = COORD_BITS;
  localparam int D     = DIR_BITS;
  localparam int RW    = 3 * C + 3 * D;
  localparam int SUM_W = C + CNT_W + 1;
  localparam int SQ    = 2 * C + 2;
  localparam int WIN   = ((SQ > TOLT_W) ? SQ : TOLT_W) + 2;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_D0SQ   = 3'd2;
  localparam logic [2:0] ST_D0SUM  = 3'd3;
  localparam logic [2:0] ST_SCAN1  = 3'd4;
  localparam logic [2:0] ST_SCAN2  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state;

  logic               use_centroid;
  logic [2:0][C-1:0]  org;
  logic               direction_check;
  logic [SHIFT_W-1:0] slack_shift;

  logic [CNT_W-1:0]              ref_count;
  logic signed [2:0][SUM_W-1:0]  sums;
  logic                          latch_valid;
  logic [2:0][C-1:0]             latch_o;
  logic                          all_found;
  logic                          overflowed;

  logic [2:0][C-1:0] q;
  logic [2:0][D-1:0] qd;
  logic [TOL_W-1:0]  md;
  logic [2:0][C-1:0] o;

  logic [2:0][SQ-1:0]  sq;
  logic [TOL2_W-1:0]   tol2;
  logic signed [WIN:0] lo;
  logic [WIN-1:0]      hi;

  logic [1:0]       comp;
  logic             div_go;
  logic             div_done;
  logic [SUM_W-1:0] div_num;
  logic [SUM_W-1:0] div_quo;
  logic             div_neg;

  logic [CNT_W-1:0] issued;
  logic             v0;
  logic [AW-1:0]    idx0;
  logic             issue;
  logic             pass_done;

  logic           out_valid;
  tpm_out_t       out_data;
  tpm_scan_ctrl_t sctrl;
  tpm_scan_stat_t sstat;
  logic [AW-1:0]  best_idx;
  logic [RW-1:0]  rdata;

  logic acc;
  logic do_load;
  logic out_free;

  assign req.ready = (state == ST_IDLE);
  assign acc       = req.valid && req.ready;
  assign do_load   = acc && req.data.action == ACT_LOAD && ref_count != CNT_W'(MAX_POINTS);
  assign out_free  = !out_valid || rsp.ready;
  assign o         = use_centroid ? latch_o : org;

  assign issue     = (state == ST_SCAN1 || state == ST_SCAN2) && issued < ref_count;
  assign pass_done = !issue && !v0 && !sstat.busy;

  assign div_neg = sums[comp][SUM_W-1];
  assign div_num = div_neg ? SUM_W'(-sums[comp]) : SUM_W'(sums[comp]);

  tpm_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (ref_count[AW-1:0]),
    .wdata ({req.data.dir_z[D-1:0], req.data.dir_y[D-1:0], req.data.dir_x[D-1:0],
             req.data.pos_z[C-1:0], req.data.pos_y[C-1:0], req.data.pos_x[C-1:0]}),
    .re    (issue),
    .raddr (issued[AW-1:0]),
    .rdata (rdata)
  );

  tpm_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (ref_count),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign sctrl.start     = (state == ST_D0SUM);
  assign sctrl.valid     = v0;
  assign sctrl.pass2     = (state == ST_SCAN2);
  assign sctrl.dir_check = direction_check;

  tpm_scan #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(C), .DIR_BITS(D)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (sctrl),
    .idx      (idx0),
    .rdata    (rdata),
    .q        (q),
    .o        (o),
    .qd       (qd),
    .lo       (lo),
    .hi       (hi),
    .tol2     (tol2),
    .stat     (sstat),
    .best_idx (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      use_centroid    <= 1'b1;
      org             <= '0;
      direction_check <= 1'b0;
      slack_shift     <= SHIFT_W'(17);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_USE_CENTROID:    use_centroid    <= cfg_wdata[0];
        CFG_ORIGIN_X:        org[0]          <= cfg_wdata[C-1:0];
        CFG_ORIGIN_Y:        org[1]          <= cfg_wdata[C-1:0];
        CFG_ORIGIN_Z:        org[2]          <= cfg_wdata[C-1:0];
        CFG_DIRECTION_CHECK: direction_check <= cfg_wdata[0];
        CFG_SLACK_SHIFT:     slack_shift     <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    logic signed [C:0]  dd;
    logic [WIN-1:0]     d0w;
    logic [WIN-1:0]     slw;
    logic [WIN-1:0]     tw;
    logic [C-1:0]       qv;
    if (rst) begin
      state       <= ST_IDLE;
      ref_count   <= '0;
      sums        <= '0;
      latch_valid <= 1'b0;
      latch_o     <= '0;
      all_found   <= 1'b1;
      overflowed  <= 1'b0;
      div_go      <= 1'b0;
      comp        <= '0;
      issued      <= '0;
      v0          <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      div_go <= 1'b0;
      v0     <= issue;
      idx0   <= issued[AW-1:0];
      if (issue) begin
        issued <= issued + 1'b1;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            q[0]  <= req.data.pos_x[C-1:0];
            q[1]  <= req.data.pos_y[C-1:0];
            q[2]  <= req.data.pos_z[C-1:0];
            qd[0] <= req.data.dir_x[D-1:0];
            qd[1] <= req.data.dir_y[D-1:0];
            qd[2] <= req.data.dir_z[D-1:0];
            md    <= req.data.match_distance;
            unique case (req.data.action)
              ACT_CLEAR: begin
                ref_count   <= '0;
                sums        <= '0;
                latch_valid <= 1'b0;
                latch_o     <= '0;
                all_found   <= 1'b1;
                overflowed  <= 1'b0;
              end
              ACT_LOAD: begin
                if (do_load) begin
                  sums[0]     <= sums[0] + SUM_W'($signed(req.data.pos_x[C-1:0]));
                  sums[1]     <= sums[1] + SUM_W'($signed(req.data.pos_y[C-1:0]));
                  sums[2]     <= sums[2] + SUM_W'($signed(req.data.pos_z[C-1:0]));
                  ref_count   <= ref_count + 1'b1;
                  latch_valid <= 1'b0;
                end else begin
                  overflowed <= 1'b1;
                end
              end
              ACT_QUERY: begin
                if (use_centroid && !latch_valid) begin
                  if (ref_count == '0) begin
                    latch_o     <= '0;
                    latch_valid <= 1'b1;
                    state       <= ST_D0SQ;
                  end else begin
                    comp   <= '0;
                    div_go <= 1'b1;
                    state  <= ST_DIV;
                  end
                end else begin
                  state <= ST_D0SQ;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            qv            = div_quo[C-1:0];
            latch_o[comp] <= div_neg ? C'(-qv) : qv;
            if (comp == 2'd2) begin
              latch_valid <= 1'b1;
              state       <= ST_D0SQ;
            end else begin
              comp   <= comp + 1'b1;
              div_go <= 1'b1;
            end
          end
        end
        ST_D0SQ: begin
          for (int k = 0; k < 3; k++) begin
            dd    = $signed({q[k][C-1], q[k]}) - $signed({o[k][C-1], o[k]});
            sq[k] <= $unsigned(SQ'(dd) * SQ'(dd));
          end
          tol2  <= md * md;
          state <= ST_D0SUM;
        end
        ST_D0SUM: begin
          d0w    = WIN'(sq[0] + sq[1] + sq[2]);
          slw    = d0w >> slack_shift;
          tw     = WIN'({md, 9'b0});
          lo     <= $signed({1'b0, d0w}) - $signed({1'b0, slw}) - $signed({1'b0, tw});
          hi     <= d0w + slw + tw;
          issued <= '0;
          state  <= ST_SCAN1;
        end
        ST_SCAN1: begin
          if (pass_done) begin
            issued <= '0;
            state  <= ST_SCAN2;
          end
        end
        ST_SCAN2: begin
          if (pass_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.found       <= sstat.found;
            out_data.match_index <= sstat.found ? IDX_W'(best_idx) : '0;
            out_data.all_found   <= all_found && sstat.found;
            out_data.overflowed  <= overflowed;
            all_found            <= all_found && sstat.found;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ref_count <= CNT_W'(MAX_POINTS))
    else $error("reference count beyond capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (acc && req.data.action == ACT_CLEAR) |=> (ref_count == '0 && !overflowed && all_found))
    else $error("clear did not empty the store");

  a_miss_drops_all: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.data.found) |-> !rsp.data.all_found)
    else $error("miss reported with all_found set");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside centroid step");

endmodule
`default_nettype wire
